[design/stepper_pulse_item_generator_core_defines.svh]
// ----------------------------------------------------------------------------
// Stepper pulse item generator: assertion macros
// Shared property wrappers for the checker, clocked on clock and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef STEPPER_PULSE_ITEM_GENERATOR_CORE_DEFINES_SVH
`define STEPPER_PULSE_ITEM_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication
`define SPIG_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define SPIG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/spig_pkg.sv]
// ----------------------------------------------------------------------------
// Stepper pulse item generator package
// Widths, limits, register indexes and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spig_pkg;

   localparam int PeriodW = 21;
   localparam int DurW    = 15;
   localparam int LimitW  = 16;
   localparam int IdleW   = 17;
   localparam int AddrW   = 3;
   localparam int DataW   = 32;

   localparam int MaxItemsPerStepDefault = 64;

   localparam logic [PeriodW-1:0] PeriodMax       = 21'd2097088;
   localparam logic [DurW-1:0]    MaxChunkUs      = 15'd32767;
   localparam logic [IdleW-1:0]   IdleCountMax    = 17'd131071;
   localparam logic [DurW-1:0]    PulseWidthReset = 15'd10;
   localparam logic [LimitW-1:0]  IdleLimitReset  = 16'd100;

   // Request kinds
   localparam logic ReqStep = 1'b0;
   localparam logic ReqTick = 1'b1;

   // Register indexes (paddr[2])
   localparam logic RegPulseWidth = 1'b0;
   localparam logic RegIdleLimit  = 1'b1;

   typedef struct packed {
      logic [DurW-1:0]   pulse_width_us;
      logic [LimitW-1:0] idle_limit_ms;
   } cfg_type;

   typedef struct packed {
      logic [PeriodW-1:0] min_val;
      logic [PeriodW-1:0] rem;
   } alu_res_type;

endpackage

`default_nettype wire

[design/spig_alu.sv]
// ----------------------------------------------------------------------------
// Shared min/remainder unit
// Returns min(a, b) and a - min(a, b); reused for period clamp,
// pulse split and chunk split.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spig_alu (
   input  wire logic [spig_pkg::PeriodW-1:0] op_a,
   input  wire logic [spig_pkg::PeriodW-1:0] op_b,
   output spig_pkg::alu_res_type             res
);
   import spig_pkg::*;

   logic a_lt_b;

   // Compare, select and subtract
   assign a_lt_b      = op_a < op_b;
   assign res.min_val = a_lt_b ? op_a : op_b;
   assign res.rem     = op_a - res.min_val;

endmodule

`default_nettype wire

[design/spig_csr.sv]
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style write/read of the pulse width and the idle limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spig_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [spig_pkg::AddrW-1:0]  paddr,
   input  wire logic [spig_pkg::DataW-1:0]  pwdata,
   output      logic [spig_pkg::DataW-1:0]  prdata,
   output      logic                        pready,
   output      spig_pkg::cfg_type           cfg
);
   import spig_pkg::*;

   logic              wr_en;
   logic              reg_sel;
   logic [DurW-1:0]   pulse_width_ff, pulse_width_in;
   logic [LimitW-1:0] idle_limit_ff, idle_limit_in;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite & pready;
   assign reg_sel = paddr[2];

   // Decode write
   always_comb begin
      pulse_width_in = pulse_width_ff;
      idle_limit_in  = idle_limit_ff;
      if (wr_en) begin
         case (reg_sel)
            RegPulseWidth: pulse_width_in = pwdata[DurW-1:0];
            RegIdleLimit:  idle_limit_in  = pwdata[LimitW-1:0];
            default:       pulse_width_in = pulse_width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_width_ff <= PulseWidthReset;
         idle_limit_ff  <= IdleLimitReset;
      end else begin
         pulse_width_ff <= pulse_width_in;
         idle_limit_ff  <= idle_limit_in;
      end
   end

   // Read back
   assign prdata = (reg_sel == RegIdleLimit) ? {{(DataW-LimitW){1'b0}}, idle_limit_ff}
                                             : {{(DataW-DurW){1'b0}}, pulse_width_ff};

   assign cfg.pulse_width_us = pulse_width_ff;
   assign cfg.idle_limit_ms  = idle_limit_ff;

endmodule

`default_nettype wire

[design/stepper_pulse_item_generator_core.sv]
// ----------------------------------------------------------------------------
// Stepper pulse item generator core
// Turns step events into step/dir pulse words and tracks driver idle time.
// ----------------------------------------------------------------------------
// A tick word yields one status word. A step word yields n pulse words, n
// running from 1 up to MAX_ITEMS_PER_STEP: the sequencer first clamps the
// period, then splits off the pulse width, then the shared min/subtract unit
// peels one chunk per cycle, each chunk a pulse word. The next request is
// taken once the sequencer is back in idle and the output slot is free;
// rsp_ready low stalls chunk emission.
`timescale 1ns / 1ps
`default_nettype none

module stepper_pulse_item_generator_core #(
   parameter int MAX_ITEMS_PER_STEP = spig_pkg::MaxItemsPerStepDefault
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // request channel
   input  wire logic                         req_valid,
   output      logic                         req_ready,
   input  wire logic                         req_type,
   input  wire logic [spig_pkg::PeriodW-1:0] req_step_period_us,
   input  wire logic                         req_step_dir,
   // response channel
   output      logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   output      logic                         rsp_item_valid,
   output      logic                         rsp_first_level,
   output      logic [spig_pkg::DurW-1:0]    rsp_first_duration,
   output      logic                         rsp_second_level,
   output      logic [spig_pkg::DurW-1:0]    rsp_second_duration,
   output      logic                         rsp_dir_level,
   output      logic                         rsp_driver_on,
   output      logic                         rsp_idle_shutoff,
   output      logic                         rsp_last_item,
   // configuration port
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [spig_pkg::AddrW-1:0]   paddr,
   input  wire logic [spig_pkg::DataW-1:0]   pwdata,
   output      logic [spig_pkg::DataW-1:0]   prdata,
   output      logic                         pready
);
   import spig_pkg::*;

   localparam int CntW = $clog2(MAX_ITEMS_PER_STEP + 1);
   localparam logic [CntW-1:0] LastCnt = CntW'(MAX_ITEMS_PER_STEP - 1);

   localparam logic [1:0] StIdle  = 2'd0;
   localparam logic [1:0] StClamp = 2'd1;
   localparam logic [1:0] StSplit = 2'd2;
   localparam logic [1:0] StEmit  = 2'd3;

   cfg_type     cfg;
   alu_res_type alu_res;

   logic [PeriodW-1:0] alu_a, alu_b;
   logic [DurW-1:0]    pulse_min1;

   logic [1:0]         state_ff, state_in;
   logic [PeriodW-1:0] low_ff, low_in;
   logic [DurW-1:0]    pulse_ff, pulse_in;
   logic               dir_ff, dir_in;
   logic [CntW-1:0]    cnt_ff, cnt_in;
   logic               first_ff, first_in;
   logic               drv_en_ff, drv_en_in;
   logic [IdleW-1:0]   idle_ff, idle_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               item_valid_ff, item_valid_in;
   logic               first_level_ff, first_level_in;
   logic [DurW-1:0]    first_dur_ff, first_dur_in;
   logic [DurW-1:0]    second_dur_ff, second_dur_in;
   logic               dir_level_ff, dir_level_in;
   logic               driver_on_ff, driver_on_in;
   logic               shutoff_ff, shutoff_in;
   logic               last_ff, last_in;

   logic               slot_free;
   logic               req_fire;
   logic               emit;
   logic               emit_last;
   logic [DurW-1:0]    chunk;
   logic [IdleW-1:0]   idle_inc;
   logic               tick_shut;

   spig_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Feed the shared unit per sequencer step
   assign pulse_min1 = (cfg.pulse_width_us == '0) ? DurW'(1) : cfg.pulse_width_us;

   always_comb begin
      alu_a = low_ff;
      case (state_ff)
         StClamp: alu_b = PeriodMax;
         StSplit: alu_b = {{(PeriodW-DurW){1'b0}}, pulse_min1};
         default: alu_b = {{(PeriodW-DurW){1'b0}}, MaxChunkUs};
      endcase
   end

   spig_alu u_alu (
      .op_a (alu_a),
      .op_b (alu_b),
      .res  (alu_res)
   );

   // Handshake
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == StIdle) && slot_free;
   assign req_fire  = req_valid && req_ready;
   assign emit      = (state_ff == StEmit) && slot_free;
   assign chunk     = alu_res.min_val[DurW-1:0];
   assign emit_last = (alu_res.rem == '0) || (cnt_ff == LastCnt);

   // Idle count update for a tick
   assign idle_inc  = (idle_ff < IdleCountMax) ? idle_ff + IdleW'(1) : idle_ff;
   assign tick_shut = drv_en_ff && (idle_inc > {1'b0, cfg.idle_limit_ms});

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      low_in    = low_ff;
      pulse_in  = pulse_ff;
      dir_in    = dir_ff;
      cnt_in    = cnt_ff;
      first_in  = first_ff;
      drv_en_in = drv_en_ff;
      idle_in   = idle_ff;
      case (state_ff)
         StIdle: begin
            if (req_fire) begin
               if (req_type == ReqTick) begin
                  if (drv_en_ff) begin
                     idle_in   = idle_inc;
                     drv_en_in = !tick_shut;
                  end
               end else begin
                  low_in    = req_step_period_us;
                  dir_in    = req_step_dir;
                  cnt_in    = '0;
                  first_in  = 1'b1;
                  drv_en_in = 1'b1;
                  idle_in   = '0;
                  state_in  = StClamp;
               end
            end
         end
         StClamp: begin
            low_in   = alu_res.min_val;
            state_in = StSplit;
         end
         StSplit: begin
            pulse_in = alu_res.min_val[DurW-1:0];
            low_in   = alu_res.rem;
            state_in = StEmit;
         end
         StEmit: begin
            if (emit) begin
               low_in   = alu_res.rem;
               cnt_in   = cnt_ff + CntW'(1);
               first_in = 1'b0;
               if (emit_last) begin
                  state_in = StIdle;
               end
            end
         end
         default: state_in = StIdle;
      endcase
   end

   // Output word
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      item_valid_in  = item_valid_ff;
      first_level_in = first_level_ff;
      first_dur_in   = first_dur_ff;
      second_dur_in  = second_dur_ff;
      dir_level_in   = dir_level_ff;
      driver_on_in   = driver_on_ff;
      shutoff_in     = shutoff_ff;
      last_in        = last_ff;
      if (req_fire && (req_type == ReqTick)) begin
         rsp_valid_in   = 1'b1;
         item_valid_in  = 1'b0;
         first_level_in = 1'b0;
         first_dur_in   = '0;
         second_dur_in  = '0;
         dir_level_in   = 1'b0;
         driver_on_in   = drv_en_ff && !tick_shut;
         shutoff_in     = tick_shut;
         last_in        = 1'b1;
      end else if (emit) begin
         rsp_valid_in   = 1'b1;
         item_valid_in  = 1'b1;
         first_level_in = first_ff;
         first_dur_in   = first_ff ? pulse_ff : chunk;
         second_dur_in  = first_ff ? chunk : DurW'(1);
         dir_level_in   = dir_ff;
         driver_on_in   = 1'b1;
         shutoff_in     = 1'b0;
         last_in        = emit_last;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         drv_en_ff    <= 1'b0;
         idle_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         drv_en_ff    <= drv_en_in;
         idle_ff      <= idle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers
   always_ff @(posedge clock) begin
      low_ff         <= low_in;
      pulse_ff       <= pulse_in;
      dir_ff         <= dir_in;
      cnt_ff         <= cnt_in;
      first_ff       <= first_in;
      item_valid_ff  <= item_valid_in;
      first_level_ff <= first_level_in;
      first_dur_ff   <= first_dur_in;
      second_dur_ff  <= second_dur_in;
      dir_level_ff   <= dir_level_in;
      driver_on_ff   <= driver_on_in;
      shutoff_ff     <= shutoff_in;
      last_ff        <= last_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_item_valid      = item_valid_ff;
   assign rsp_first_level     = first_level_ff;
   assign rsp_first_duration  = first_dur_ff;
   assign rsp_second_level    = 1'b0;
   assign rsp_second_duration = second_dur_ff;
   assign rsp_dir_level       = dir_level_ff;
   assign rsp_driver_on       = driver_on_ff;
   assign rsp_idle_shutoff    = shutoff_ff;
   assign rsp_last_item       = last_ff;

endmodule

`default_nettype wire

[design/spig_checker.sv]
// ----------------------------------------------------------------------------
// Stepper pulse item generator port checker
// Watches the top-level ports and flags protocol or sequencing slips.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "stepper_pulse_item_generator_core_defines.svh"

module spig_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_ready,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic                         rsp_item_valid,
   input wire logic [spig_pkg::DurW-1:0]    rsp_first_duration,
   input wire logic [spig_pkg::DurW-1:0]    rsp_second_duration,
   input wire logic                         rsp_second_level,
   input wire logic                         rsp_driver_on,
   input wire logic                         rsp_idle_shutoff,
   input wire logic                         rsp_last_item
);
   import spig_pkg::*;

   // Hold a stalled word
   `SPIG_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_first_duration) && $stable(rsp_second_duration) && $stable(rsp_last_item), "stalled response word changed")

   // Status words are single, empty words
   `SPIG_ASSERT_NOW(a_tick_word, rsp_valid && !rsp_item_valid, rsp_last_item && (rsp_first_duration == '0) && (rsp_second_duration == '0), "tick status word malformed")

   // A shutoff leaves the driver off
   `SPIG_ASSERT_NOW(a_shutoff, rsp_valid && rsp_idle_shutoff, !rsp_driver_on && !rsp_item_valid, "idle shutoff with driver on")

   // Pulse words keep the driver on and end low
   `SPIG_ASSERT_NOW(a_pulse_word, rsp_valid && rsp_item_valid, rsp_driver_on && !rsp_second_level && !rsp_idle_shutoff, "pulse word status wrong")

   // No new request while a step still emits
   `SPIG_ASSERT_NOW(a_busy, rsp_valid && rsp_item_valid && !rsp_last_item, !req_ready, "request taken mid-step")

endmodule

bind stepper_pulse_item_generator_core spig_checker u_spig_checker (
   .clock               (clock),
   .reset               (reset),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_item_valid      (rsp_item_valid),
   .rsp_first_duration  (rsp_first_duration),
   .rsp_second_duration (rsp_second_duration),
   .rsp_second_level    (rsp_second_level),
   .rsp_driver_on       (rsp_driver_on),
   .rsp_idle_shutoff    (rsp_idle_shutoff),
   .rsp_last_item       (rsp_last_item)
);

`default_nettype wire
